/* design/pppb_pkg.sv */
`default_nettype none
package pppb_pkg;

  // input item kinds, carried on s_tuser
  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  typedef enum logic [2:0] {
    REG_RED_MASK    = 3'd0,
    REG_GREEN_MASK  = 3'd1,
    REG_BLUE_MASK   = 3'd2,
    REG_OUT_BYTES   = 3'd3,
    REG_BLUR_EN     = 3'd4,
    REG_HSCALE      = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] RED_MASK_RST   = 32'h0000_F800;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_07E0;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_001F;
  localparam logic [2:0]  OUT_BYTES_RST  = 3'd2;

  // blend weights and the divide by 100 done as a reciprocal multiply
  localparam logic [6:0]  W_MAIN_RG   = 7'd80;
  localparam logic [6:0]  W_PREV_RG   = 7'd20;
  localparam logic [6:0]  W_MAIN_B    = 7'd90;
  localparam logic [6:0]  W_PREV_B    = 7'd10;
  localparam logic [6:0]  W_FULL      = 7'd100;
  localparam logic [12:0] DIV_RECIP   = 13'd5243;
  localparam int          DIV_SHIFT   = 19;
  localparam logic [8:0]  CHAN_MAX    = 9'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = 2;
  localparam int QCW = 3;

  typedef struct packed {
    logic [23:0] cur;
    logic [23:0] prev;
  } pix_entry_t;

  typedef struct packed {
    logic       zero;
    logic [4:0] low;
    logic [3:0] down;
  } chan_cfg_t;

  typedef struct packed {
    logic        blur;
    logic        narrow;
    logic [31:0] byte_mask;
    chan_cfg_t   red;
    chan_cfg_t   green;
    chan_cfg_t   blue;
  } cfg_t;

  function automatic chan_cfg_t chan_cfg(input logic [31:0] mask);
    chan_cfg_t   c;
    logic [31:0] iso;
    logic [5:0]  cnt;
    c.low = 5'd0;
    iso   = mask & (~mask + 32'd1);
    cnt   = 6'($countones(mask));
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) c.low = c.low | 5'(i);
    end
    c.zero = (mask == 32'd0);
    c.down = (cnt < 6'd8) ? 4'(6'd8 - cnt) : 4'd0;
    return c;
  endfunction

  function automatic logic [31:0] place(input logic [7:0] val, input chan_cfg_t c,
                                        input logic narrow);
    logic [7:0] v;
    v = narrow ? (val >> c.down) : val;
    return c.zero ? 32'd0 : (32'(v) << c.low);
  endfunction

endpackage
`default_nettype wire

/* design/pppb_cfg.sv */
`default_nettype none
module pppb_cfg #(
  parameter int MAX_HSCALE = 4,
  parameter int CW = 3
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [2:0]        cfg_index,
  input  wire  [31:0]       cfg_data,
  output pppb_pkg::cfg_t    cfg,
  output logic [CW-1:0]     copies_last
);

  logic [2:0] hs;

  assign cfg_ready = 1'b1;
  assign hs        = cfg_data[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blur      <= 1'b0;
      cfg.narrow    <= 1'b1;
      cfg.byte_mask <= 32'h0000_FFFF;
      cfg.red       <= pppb_pkg::chan_cfg(pppb_pkg::RED_MASK_RST);
      cfg.green     <= pppb_pkg::chan_cfg(pppb_pkg::GREEN_MASK_RST);
      cfg.blue      <= pppb_pkg::chan_cfg(pppb_pkg::BLUE_MASK_RST);
      copies_last   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pppb_pkg::REG_RED_MASK:   cfg.red   <= pppb_pkg::chan_cfg(cfg_data);
        pppb_pkg::REG_GREEN_MASK: cfg.green <= pppb_pkg::chan_cfg(cfg_data);
        pppb_pkg::REG_BLUE_MASK:  cfg.blue  <= pppb_pkg::chan_cfg(cfg_data);
        pppb_pkg::REG_OUT_BYTES: begin
          // 0 and 1 behave as 2 bytes, 5 and up as 4
          cfg.narrow <= (cfg_data[2:0] <= 3'd2);
          if (cfg_data[2:0] <= 3'd2) cfg.byte_mask <= 32'h0000_FFFF;
          else if (cfg_data[2:0] == 3'd3) cfg.byte_mask <= 32'h00FF_FFFF;
          else cfg.byte_mask <= 32'hFFFF_FFFF;
        end
        pppb_pkg::REG_BLUR_EN:    cfg.blur  <= cfg_data[0];
        pppb_pkg::REG_HSCALE: begin
          if (hs == 3'd0) copies_last <= '0;
          else if (32'(hs) > MAX_HSCALE) copies_last <= CW'(MAX_HSCALE - 1);
          else copies_last <= CW'(hs - 3'd1);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/pppb_front.sv */
`default_nettype none
module pppb_front #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [39:0]                s_tdata,
  input  wire                        s_tuser,
  input  wire  [pppb_pkg::QCW-1:0]   q_count,
  output logic                       push,
  output pppb_pkg::pix_entry_t       push_data
);

  localparam int AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW1 = pppb_pkg::QCW + 1;

  logic [23:0]    mem [PALETTE_ENTRIES];
  logic [7:0]     idx;
  logic           line_start;
  logic [23:0]    wr_rgb;
  logic [7:0]     prev_idx;
  logic [7:0]     prev_addr;
  logic           accept;
  logic           rd_valid;
  logic           rd_cur_ok;
  logic           rd_prev_ok;
  logic [23:0]    rd_cur;
  logic [23:0]    rd_prev;
  logic [CW1-1:0] fill;

  assign idx        = s_tdata[7:0];
  assign line_start = s_tdata[8];
  assign wr_rgb     = {s_tdata[16:9], s_tdata[24:17], s_tdata[32:25]};
  assign prev_addr  = line_start ? 8'd0 : prev_idx;

  // room for the read in flight as well as this one
  assign fill     = CW1'(q_count) + CW1'(rd_valid);
  assign s_tready = (fill < CW1'(pppb_pkg::QUEUE_DEPTH));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept && s_tuser == pppb_pkg::CMD_PAL_WRITE && 32'(idx) < PALETTE_ENTRIES) begin
      mem[idx[AW-1:0]] <= wr_rgb;
    end
  end

  always_ff @(posedge clk) begin
    rd_cur     <= mem[idx[AW-1:0]];
    rd_prev    <= mem[prev_addr[AW-1:0]];
    rd_cur_ok  <= (32'(idx) < PALETTE_ENTRIES);
    rd_prev_ok <= (32'(prev_addr) < PALETTE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      prev_idx <= 8'd0;
    end else begin
      rd_valid <= accept && s_tuser == pppb_pkg::CMD_PIXEL;
      if (accept && s_tuser == pppb_pkg::CMD_PIXEL) prev_idx <= idx;
    end
  end

  assign push           = rd_valid;
  assign push_data.cur  = rd_cur_ok ? rd_cur : 24'd0;
  assign push_data.prev = rd_prev_ok ? rd_prev : 24'd0;

endmodule
`default_nettype wire

/* design/pppb_queue.sv */
`default_nettype none
module pppb_queue (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  input  pppb_pkg::pix_entry_t       push_data,
  input  wire                        pop,
  output pppb_pkg::pix_entry_t       head,
  output logic                       not_empty,
  output logic [pppb_pkg::QCW-1:0]   count
);

  pppb_pkg::pix_entry_t          slots [pppb_pkg::QUEUE_DEPTH];
  logic [pppb_pkg::QAW-1:0]      wptr;
  logic [pppb_pkg::QAW-1:0]      rptr;

  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/pppb_back.sv */
`default_nettype none
module pppb_back #(
  parameter int CW = 3
) (
  input  wire                    clk,
  input  wire                    rst,
  input  pppb_pkg::cfg_t         cfg,
  input  wire  [CW-1:0]          copies_last,
  input  wire                    q_valid,
  input  pppb_pkg::pix_entry_t   head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [31:0]            m_tdata,
  output logic                   m_tlast
);

  logic        s1_valid;
  logic [14:0] s1_num [3];
  logic        s2_valid;
  logic [7:0]  s2_ch [3];
  logic [CW-1:0] o_cnt;
  logic        o_last;
  logic        o_take;
  logic        s2_take;
  logic        s1_take;
  logic [14:0] num [3];
  logic [27:0] prod [3];
  logic [8:0]  quo [3];
  logic [7:0]  cur_c [3];
  logic [7:0]  prv_c [3];

  assign cur_c[0] = head.cur[23:16];
  assign cur_c[1] = head.cur[15:8];
  assign cur_c[2] = head.cur[7:0];
  assign prv_c[0] = head.prev[23:16];
  assign prv_c[1] = head.prev[15:8];
  assign prv_c[2] = head.prev[7:0];

  // without blur the channel is scaled by 100 so the same divide returns it
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!cfg.blur) num[i] = 15'(cur_c[i]) * 15'(pppb_pkg::W_FULL);
      else if (i == 2) num[i] = 15'(cur_c[i]) * 15'(pppb_pkg::W_MAIN_B)
                                + 15'(prv_c[i]) * 15'(pppb_pkg::W_PREV_B);
      else num[i] = 15'(cur_c[i]) * 15'(pppb_pkg::W_MAIN_RG)
                    + 15'(prv_c[i]) * 15'(pppb_pkg::W_PREV_RG);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = 28'(s1_num[i]) * 28'(pppb_pkg::DIV_RECIP);
      quo[i]  = prod[i][pppb_pkg::DIV_SHIFT +: 9];
    end
  end

  assign o_last  = (o_cnt == copies_last);
  assign o_take  = !m_tvalid || (m_tready && o_last);
  assign s2_take = !s2_valid || o_take;
  assign s1_take = !s1_valid || s2_take;
  assign pop     = q_valid && s1_take;
  assign m_tlast = o_last;

  always_ff @(posedge clk) begin
    if (s1_take) begin
      for (int i = 0; i < 3; i++) s1_num[i] <= num[i];
    end
    if (s2_take) begin
      for (int i = 0; i < 3; i++) begin
        s2_ch[i] <= (quo[i] > pppb_pkg::CHAN_MAX) ? pppb_pkg::CHAN_MAX[7:0] : quo[i][7:0];
      end
    end
    if (o_take) begin
      m_tdata <= (pppb_pkg::place(s2_ch[0], cfg.red, cfg.narrow)
                | pppb_pkg::place(s2_ch[1], cfg.green, cfg.narrow)
                | pppb_pkg::place(s2_ch[2], cfg.blue, cfg.narrow)) & cfg.byte_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
      o_cnt    <= '0;
    end else begin
      if (s1_take) s1_valid <= q_valid;
      if (s2_take) s2_valid <= s1_valid;
      if (o_take) begin
        m_tvalid <= s2_valid;
        o_cnt    <= '0;
      end else if (m_tready) begin
        // one more copy of the held pixel goes out
        o_cnt <= o_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/palette_pixel_blur_packer_top.sv */
`default_nettype none
// Palette pixel packer. Each input transfer is either a palette entry write
// (s_tuser high) or a pixel index (s_tuser low). Pixels are looked up in the
// palette, optionally blended with the previous pixel on the line (entry 0
// at a line start), and packed into m_tdata by the three channel masks; each
// pixel is sent horizontal_scale times (0 as 1, at most MAX_HSCALE), m_tlast
// marking the final copy. Palette writes produce nothing. The front end takes
// one item per cycle while the queue has room; with a scale of 1 one pixel
// leaves per cycle while m_tready is high, otherwise the output register holds
// a pixel until all its copies are out. With the queue empty, a pixel passes
// the palette read register, queue, blend multiply, reciprocal divide and
// pack register before m_tvalid rises.
// Configuration must be written while the block is idle, and every palette
// entry must be written before a pixel or a blend reads it.
module palette_pixel_blur_packer_top #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_HSCALE = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // pixel_index, line_start, red_in, green_in, blue_in, zero pad
  input  wire         s_tuser,   // command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // pixel_value
  output logic        m_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam int CW = $clog2(MAX_HSCALE + 1);

  pppb_pkg::cfg_t                cfg;
  logic [CW-1:0]                 copies_last;
  logic [pppb_pkg::QCW-1:0]      q_count;
  logic                          push;
  pppb_pkg::pix_entry_t          push_data;
  logic                          pop;
  pppb_pkg::pix_entry_t          head;
  logic                          q_valid;

  pppb_cfg #(.MAX_HSCALE(MAX_HSCALE), .CW(CW)) u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg), .copies_last(copies_last)
  );

  pppb_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .q_count(q_count),
    .push(push), .push_data(push_data)
  );

  pppb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .head(head), .not_empty(q_valid), .count(q_count)
  );

  pppb_back #(.CW(CW)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .copies_last(copies_last),
    .q_valid(q_valid), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
`default_nettype wire

/* sim/palette_pack_checker.sv */
`timescale 1ns / 1ps
module palette_pack_checker #(
  parameter int MAX_REPEAT = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [39:0] s_tdata,   // pixel_index, line_start, red_in, green_in, blue_in, zero pad
  input  wire         s_tuser,   // command
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [31:0] m_tdata,   // pixel_value
  input  wire         m_tlast,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          pixels_in,
  output int          writes_in,
  output int          copies_out
);

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } pixel_copy_t;

  pixel_copy_t copies_due[$];
  pixel_copy_t want;

  logic [23:0] pal_rgb [256];
  logic [31:0] red_mask, green_mask, blue_mask;
  logic [2:0]  out_bytes, hscale;
  logic        blur_on;
  logic [7:0]  prev_idx;

  function automatic logic [31:0] put_channel(input logic [7:0] val, input logic [31:0] mask,
                                              input bit narrow);
    int          lowest;
    int          ones;
    logic [31:0] v;
    lowest = -1;
    ones   = 0;
    for (int i = 0; i < 32; i++) begin
      if (mask[i]) begin
        if (lowest < 0) lowest = i;
        ones++;
      end
    end
    if (mask == 32'd0) return 32'd0;
    v = {24'd0, val};
    if (narrow && ones < 8) v = v >> (8 - ones);
    // anything pushed past bit 31 falls off
    return v << lowest;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] cur_c, input logic [7:0] prev_c,
                                       input int w_cur, input int w_prev);
    return 8'((int'(cur_c) * w_cur + int'(prev_c) * w_prev) / 100);
  endfunction

  task automatic predict_pixel(input logic [7:0] idx, input logic ls);
    logic [23:0] cur, prv;
    logic [7:0]  r, g, b;
    logic [31:0] pix;
    int          nbytes, ncopies;
    bit          narrow;
    cur = pal_rgb[idx];
    r = cur[23:16];
    g = cur[15:8];
    b = cur[7:0];
    if (blur_on) begin
      // neighbour is entry 0 at the start of a line
      prv = pal_rgb[ls ? 8'd0 : prev_idx];
      r = blend(r, prv[23:16], 80, 20);
      g = blend(g, prv[15:8], 80, 20);
      b = blend(b, prv[7:0], 90, 10);
    end
    prev_idx = idx;
    nbytes = (out_bytes < 3'd2) ? 2 : (out_bytes > 3'd4) ? 4 : int'(out_bytes);
    narrow = (nbytes == 2);
    pix = put_channel(r, red_mask, narrow) | put_channel(g, green_mask, narrow) |
          put_channel(b, blue_mask, narrow);
    if (nbytes == 2) pix[31:16] = 16'd0;
    else if (nbytes == 3) pix[31:24] = 8'd0;
    ncopies = (hscale == 3'd0) ? 1 : (int'(hscale) > MAX_REPEAT) ? MAX_REPEAT : int'(hscale);
    for (int k = 0; k < ncopies; k++) copies_due.push_back('{pix, k == ncopies - 1});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      copies_due.delete();
      red_mask   = pppb_pkg::RED_MASK_RST;
      green_mask = pppb_pkg::GREEN_MASK_RST;
      blue_mask  = pppb_pkg::BLUE_MASK_RST;
      out_bytes  = pppb_pkg::OUT_BYTES_RST;
      blur_on    = 1'b0;
      hscale     = 3'd1;
      prev_idx   = 8'd0;
      mismatches = 0;
      pixels_in  = 0;
      writes_in  = 0;
      copies_out = 0;
      pending   <= 0;
    end else begin
      // compare before taking new input so a stray copy cannot hide behind a fresh one
      if (m_tvalid && m_tready) begin
        copies_out++;
        if (copies_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: output transfer with nothing expected: value %h last %b",
                     $realtime, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = copies_due.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.last) begin
            if (mismatches < 10)
              $display("%0t: pixel mismatch: expected value %h last %b, got value %h last %b",
                       $realtime, want.value, want.last, m_tdata, m_tlast);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pppb_pkg::REG_RED_MASK:   red_mask   = cfg_data;
          pppb_pkg::REG_GREEN_MASK: green_mask = cfg_data;
          pppb_pkg::REG_BLUE_MASK:  blue_mask  = cfg_data;
          pppb_pkg::REG_OUT_BYTES:  out_bytes  = cfg_data[2:0];
          pppb_pkg::REG_BLUR_EN:    blur_on    = cfg_data[0];
          pppb_pkg::REG_HSCALE:     hscale     = cfg_data[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == pppb_pkg::CMD_PAL_WRITE) begin
          pal_rgb[s_tdata[7:0]] = {s_tdata[16:9], s_tdata[24:17], s_tdata[32:25]};
          writes_in++;
        end else begin
          predict_pixel(s_tdata[7:0], s_tdata[8]);
          pixels_in++;
        end
      end
      pending <= copies_due.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_HSCALE      = 4;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 10;
  localparam int SETTLE_CYCLES   = 12;

  typedef struct {
    logic [31:0] red_m;
    logic [31:0] green_m;
    logic [31:0] blue_m;
    logic [2:0]  bytes;
    logic        blur;
    logic [2:0]  scale;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatches, pending, pixels_in, writes_in, copies_out;
  int settings_used;
  bit src_idle, sink_idle;
  bit written [256];
  logic [7:0] written_idx [$];

  palette_pixel_blur_packer_top #(
    .PALETTE_ENTRIES(256),
    .MAX_HSCALE(MAX_HSCALE)
  ) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  palette_pack_checker #(
    .MAX_REPEAT(MAX_HSCALE)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .pixels_in(pixels_in),
    .writes_in(writes_in), .copies_out(copies_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stall before each output transfer while sink_idle is set
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic ls,
                           input logic [23:0] rgb);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, rgb[7:0], rgb[15:8], rgb[23:16], ls, idx};
    do @(posedge clk); while (!s_tready);
    if (cmd == pppb_pkg::CMD_PAL_WRITE && !written[idx]) begin
      written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endtask

  // hold the input off until every predicted copy has gone out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input pppb_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input setting_t st);
    drain();
    // palette writes give no copies, so let the pipeline empty
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(pppb_pkg::REG_RED_MASK, st.red_m);
    write_reg(pppb_pkg::REG_GREEN_MASK, st.green_m);
    write_reg(pppb_pkg::REG_BLUE_MASK, st.blue_m);
    write_reg(pppb_pkg::REG_OUT_BYTES, 32'(st.bytes));
    write_reg(pppb_pkg::REG_BLUR_EN, 32'(st.blur));
    write_reg(pppb_pkg::REG_HSCALE, 32'(st.scale));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item();
    logic [23:0] rgb;
    rgb = 24'($urandom);
    // pixels only ever read entries that have been loaded
    if ($urandom_range(0, 4) == 0)
      send_item(pppb_pkg::CMD_PAL_WRITE, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), rgb);
    else
      send_item(pppb_pkg::CMD_PIXEL, written_idx[$urandom_range(0, written_idx.size() - 1)],
                $urandom_range(0, 3) == 0, rgb);
  endtask

  initial begin
    setting_t st;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    settings_used = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    apply_setting('{32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 3'd2, 1'b1, 3'd1});
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'h00, 1'b0, 24'hFF_FF_FF);
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'hFF, 1'b1, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'hAA, 1'b0, 24'hFF_00_80);
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'h55, 1'b0, 24'h01_FE_7F);
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'h01, 1'b0, 24'h12_34_56);
    send_item(pppb_pkg::CMD_PIXEL, 8'hFF, 1'b1, 24'hFF_FF_FF);
    send_item(pppb_pkg::CMD_PIXEL, 8'h00, 1'b0, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'hAA, 1'b0, 24'h5A_A5_3C);
    send_item(pppb_pkg::CMD_PIXEL, 8'h55, 1'b0, 24'h00_00_00);
    // a palette write between pixels must not move the blend neighbour
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'h02, 1'b0, 24'hAB_CD_EF);
    send_item(pppb_pkg::CMD_PIXEL, 8'h01, 1'b0, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'h00, 1'b1, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'h02, 1'b0, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PAL_WRITE, 8'h00, 1'b0, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'hFF, 1'b1, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'hFF, 1'b0, 24'h00_00_00);
    send_item(pppb_pkg::CMD_PIXEL, 8'hAA, 1'b1, 24'h00_00_00);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: st = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 3'd4, 1'b0, 3'd2};
        1: st = '{32'hF000_0000, 32'h00FF_0000, 32'h0000_FF00, 3'd4, 1'b1, 3'd4};
        2: st = '{32'h0000_0000, 32'h000F_F000, 32'h8000_0000, 3'd0, 1'b1, 3'd0};
        3: st = '{32'hFFFF_FFFF, 32'h0000_0F00, 32'h0000_0003, 3'd1, 1'b0, 3'd5};
        4: st = '{32'h0000_03FF, 32'h000F_FC00, 32'h3FF0_0000, 3'd3, 1'b1, 3'd3};
        5: st = '{$urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
                  $urandom >> $urandom_range(0, 31), 3'd5, 1'($urandom_range(0, 1)), 3'd6};
        6: st = '{$urandom, $urandom >> $urandom_range(0, 31),
                  $urandom >> $urandom_range(0, 31), 3'd7, 1'b1, 3'd7};
        default: st = '{$urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
                        $urandom >> $urandom_range(0, 31), 3'($urandom_range(0, 7)),
                        1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))};
      endcase
      // first random phase runs flat out on both sides
      src_idle  = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      apply_setting(st);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 19) == 0) drain();
        random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d output transfers from %0d pixels and %0d palette writes",
             copies_out, pixels_in, writes_in);
    $display("%0d register settings, incl. zero and full masks, odd byte and scale codes",
             settings_used);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
